FILE: rtl/length_prefixed_request_deframer_core_assert.svh
// Assertion macros for the length-prefixed request deframer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define LPRD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LPRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LPRD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define LPRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/lprd_pkg.sv
// Package of the length-prefixed request deframer: result type, error codes,
// register indexes and reset limits. No dependencies.
package lprd_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 26;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_FRAME_BYTES = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ARGUMENTS   = 1'd1;

   localparam logic [25:0] MAX_FRAME_BYTES_RESET = 26'(32 << 20);
   localparam logic [20:0] MAX_ARGUMENTS_RESET   = 21'(200 * 1000);

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_FRAME_LEN = 3'd1;
   localparam logic [2:0] ERR_ARG_COUNT = 3'd2;
   localparam logic [2:0] ERR_OVERRUN   = 3'd3;
   localparam logic [2:0] ERR_TRAILING  = 3'd4;
   localparam logic [2:0] ERR_HALTED    = 3'd5;

   typedef struct packed {
      logic [7:0]  arg_byte;
      logic        arg_valid;
      logic [19:0] arg_index;
      logic        arg_end;
      logic        frame_done;
      logic [2:0]  error_code;
   } result_type;

endpackage

FILE: rtl/lprd_ifs.sv
// Channel interfaces of the deframer: request bytes, results and register writes.
// Depends on lprd_pkg.
interface lprd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface lprd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  arg_byte;
   logic        arg_valid;
   logic [19:0] arg_index;
   logic        arg_end;
   logic        frame_done;
   logic [2:0]  error_code;
   modport source (output valid, output arg_byte, output arg_valid, output arg_index,
                   output arg_end, output frame_done, output error_code, input ready);
   modport sink   (input valid, input arg_byte, input arg_valid, input arg_index,
                   input arg_end, input frame_done, input error_code, output ready);
endinterface

interface lprd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [lprd_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [lprd_pkg::CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/lprd_parse.sv
// Frame parser: header assembly, length and count tracking, one result per byte.
// Depends on lprd_pkg and the assertion macro header.
`include "length_prefixed_request_deframer_core_assert.svh"

module lprd_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            in_byte,
   input  logic [25:0]           max_frame_bytes,
   input  logic [20:0]           max_arguments,
   output lprd_pkg::result_type  result
);

   localparam logic [2:0] PH_LEN   = 3'd0;
   localparam logic [2:0] PH_COUNT = 3'd1;
   localparam logic [2:0] PH_ALEN  = 3'd2;
   localparam logic [2:0] PH_DATA  = 3'd3;
   localparam logic [2:0] PH_HALT  = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  pos_ff, pos_in;
   logic [23:0] asm_ff, asm_in;
   logic [25:0] frame_left_ff, frame_left_in;
   logic [20:0] args_left_ff, args_left_in;
   logic [25:0] arg_left_ff, arg_left_in;
   logic [19:0] counter_ff, counter_in;

   logic [31:0] word;
   logic [25:0] frame_dec;
   logic [25:0] arg_dec;
   logic        finish;
   logic        check_next;

   assign word      = {asm_ff, in_byte};
   assign frame_dec = (frame_left_ff != 26'd0) ? frame_left_ff - 26'd1 : frame_left_ff;
   assign arg_dec   = (arg_left_ff != 26'd0) ? arg_left_ff - 26'd1 : arg_left_ff;

   always_comb begin
      result        = '0;
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      asm_in        = asm_ff;
      frame_left_in = frame_left_ff;
      args_left_in  = args_left_ff;
      arg_left_in   = arg_left_ff;
      counter_in    = counter_ff;
      finish        = 1'b0;
      check_next    = 1'b0;

      case (phase_ff)
         PH_DATA: begin
            result.arg_byte  = in_byte;
            result.arg_valid = 1'b1;
            result.arg_index = counter_ff;
            frame_left_in    = frame_dec;
            arg_left_in      = arg_dec;
            finish           = (arg_dec == 26'd0);
         end
         PH_LEN, PH_COUNT, PH_ALEN: begin
            asm_in = word[23:0];
            if (phase_ff != PH_LEN) begin
               frame_left_in = frame_dec;
            end
            pos_in = pos_ff + 2'd1;
            if (pos_ff == 2'd3) begin
               asm_in = '0;
               case (phase_ff)
                  PH_LEN: begin
                     if (word > {6'd0, max_frame_bytes}) begin
                        result.error_code = lprd_pkg::ERR_FRAME_LEN;
                        phase_in          = PH_HALT;
                     end else begin
                        frame_left_in = word[25:0];
                        if (word[25:0] < 26'd4) begin
                           result.error_code = lprd_pkg::ERR_OVERRUN;
                           phase_in          = PH_HALT;
                        end else begin
                           phase_in = PH_COUNT;
                        end
                     end
                  end
                  PH_COUNT: begin
                     if (word > {11'd0, max_arguments}) begin
                        result.error_code = lprd_pkg::ERR_ARG_COUNT;
                        phase_in          = PH_HALT;
                     end else begin
                        args_left_in = word[20:0];
                        counter_in   = '0;
                        check_next   = 1'b1;
                     end
                  end
                  default: begin
                     if (word > {6'd0, frame_dec}) begin
                        result.error_code = lprd_pkg::ERR_OVERRUN;
                        phase_in          = PH_HALT;
                     end else if (word == 32'd0) begin
                        finish = 1'b1;
                     end else begin
                        arg_left_in = word[25:0];
                        phase_in    = PH_DATA;
                     end
                  end
               endcase
            end
         end
         default: begin
            result.error_code = lprd_pkg::ERR_HALTED;
         end
      endcase

      if (finish) begin
         result.arg_end   = 1'b1;
         result.arg_index = counter_ff;
         counter_in       = counter_ff + 20'd1;
         if (args_left_ff != 21'd0) begin
            args_left_in = args_left_ff - 21'd1;
         end
         check_next = 1'b1;
      end

      if (check_next) begin
         if (args_left_in == 21'd0) begin
            if (frame_left_in == 26'd0) begin
               result.frame_done = 1'b1;
               phase_in          = PH_LEN;
            end else begin
               result.error_code = lprd_pkg::ERR_TRAILING;
               phase_in          = PH_HALT;
            end
         end else if (frame_left_in < 26'd4) begin
            result.error_code = lprd_pkg::ERR_OVERRUN;
            phase_in          = PH_HALT;
         end else begin
            phase_in = PH_ALEN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         pos_ff        <= '0;
         asm_ff        <= '0;
         frame_left_ff <= '0;
         args_left_ff  <= '0;
         arg_left_ff   <= '0;
         counter_ff    <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         asm_ff        <= asm_in;
         frame_left_ff <= frame_left_in;
         args_left_ff  <= args_left_in;
         arg_left_ff   <= arg_left_in;
         counter_ff    <= counter_in;
      end
   end

   `LPRD_ASSERT_NEXT(a_halt_sticks, clock, reset, phase_ff == PH_HALT, phase_ff == PH_HALT, "halt left")
   `LPRD_ASSERT_SAME(a_data_has_bytes, clock, reset, phase_ff == PH_DATA, arg_left_ff != 26'd0, "empty data phase")
   `LPRD_ASSERT_SAME(a_data_aligned, clock, reset, phase_ff == PH_DATA, pos_ff == 2'd0, "header position off")

endmodule

FILE: rtl/lprd_out_buf.sv
// Result register with a skid stage so a request is taken while a result waits.
// Depends on lprd_pkg and the assertion macro header.
`include "length_prefixed_request_deframer_core_assert.svh"

module lprd_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lprd_pkg::result_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lprd_pkg::result_type  out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   lprd_pkg::result_type main_ff, main_in;
   lprd_pkg::result_type skid_ff, skid_in;
   logic                 in_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = in_fire;
         end
      end else if (in_fire) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   `LPRD_ASSERT_SAME(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff, "skid without main")
   `LPRD_ASSERT_NEXT(a_stall_keeps, clock, reset, main_valid_ff && !out_ready, main_valid_ff, "result dropped")
   `LPRD_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && out_ready, main_ff == $past(skid_ff), "skid lost")

endmodule

FILE: rtl/length_prefixed_request_deframer_core.sv
// Length-prefixed request deframer, top level. Depends on lprd_pkg, lprd_ifs,
// lprd_parse and lprd_out_buf.
// A result is registered in the main register, or in the skid register while one waits.
// Throughput: one request per cycle while the skid register is empty.
// Reset: parser returns to waiting for a frame length, results are flushed,
// limits return to 32 MiB frame body and 200000 arguments.
module length_prefixed_request_deframer_core (
   input  logic        clock,
   input  logic        reset,
   lprd_req_if.sink    req_ch,
   lprd_rsp_if.source  rsp_ch,
   lprd_csr_if.sink    csr_ch
);

   logic [25:0]          max_frame_ff;
   logic [20:0]          max_args_ff;
   logic                 step;
   logic                 buf_ready;
   lprd_pkg::result_type result;
   lprd_pkg::result_type out_data;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= lprd_pkg::MAX_FRAME_BYTES_RESET;
         max_args_ff  <= lprd_pkg::MAX_ARGUMENTS_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            lprd_pkg::CSR_MAX_FRAME_BYTES: max_frame_ff <= csr_ch.data;
            lprd_pkg::CSR_MAX_ARGUMENTS:   max_args_ff  <= csr_ch.data[20:0];
            default: ;
         endcase
      end
   end

   assign req_ch.ready = buf_ready;
   assign step         = req_ch.valid && buf_ready;

   lprd_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .in_byte         (req_ch.in_byte),
      .max_frame_bytes (max_frame_ff),
      .max_arguments   (max_args_ff),
      .result          (result)
   );

   lprd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (buf_ready),
      .in_data   (result),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.arg_byte   = out_data.arg_byte;
   assign rsp_ch.arg_valid  = out_data.arg_valid;
   assign rsp_ch.arg_index  = out_data.arg_index;
   assign rsp_ch.arg_end    = out_data.arg_end;
   assign rsp_ch.frame_done = out_data.frame_done;
   assign rsp_ch.error_code = out_data.error_code;

endmodule

FILE: tb/length_prefixed_request_deframer_core_checker.sv
// Checker for the length-prefixed request deframer: watches the request, result and
// register channels, predicts every result and compares it field by field.
// Depends on lprd_pkg and lprd_ifs.
module length_prefixed_request_deframer_core_checker (
   input  logic        clock,
   input  logic        reset,
   lprd_req_if         req_mon,
   lprd_rsp_if         rsp_mon,
   lprd_csr_if         csr_mon,
   input  logic        run_done,
   output int unsigned fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      AWAIT_LENGTH,
      AWAIT_COUNT,
      AWAIT_ARG_LENGTH,
      ARG_DATA,
      HALTED
   } parse_stage_type;

   parse_stage_type stage;
   logic [1:0]   field_pos;
   logic [31:0]  word_acc;
   logic [25:0]  body_left;
   logic [20:0]  args_pending;
   logic [25:0]  data_left;
   logic [19:0]  arg_number;
   logic [25:0]  limit_frame;
   logic [20:0]  limit_args;

   lprd_pkg::result_type expected_results[$];
   int unsigned  mismatches = 0;
   int unsigned  results_seen = 0;
   logic         end_checked = 1'b0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [19:0] got,
                              input logic [19:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                   results_seen, name, got, want));
   endtask

   function automatic void stop_with(inout lprd_pkg::result_type r, input logic [2:0] code);
      r.error_code = code;
      stage = HALTED;
   endfunction

   function automatic void next_item(inout lprd_pkg::result_type r);
      if (args_pending == 0) begin
         if (body_left == 0) begin
            r.frame_done = 1'b1;
            stage = AWAIT_LENGTH;
         end else begin
            stop_with(r, lprd_pkg::ERR_TRAILING);
         end
      end else if (body_left < 4) begin
         stop_with(r, lprd_pkg::ERR_OVERRUN);
      end else begin
         stage = AWAIT_ARG_LENGTH;
      end
   endfunction

   function automatic void close_arg(inout lprd_pkg::result_type r);
      r.arg_end = 1'b1;
      r.arg_index = arg_number;
      arg_number++;
      if (args_pending != 0) args_pending--;
      next_item(r);
   endfunction

   function automatic lprd_pkg::result_type deframe_byte(input logic [7:0] b);
      lprd_pkg::result_type r;
      logic [31:0] w;
      r = '0;
      if (stage == ARG_DATA) begin
         r.arg_byte = b;
         r.arg_valid = 1'b1;
         r.arg_index = arg_number;
         if (body_left != 0) body_left--;
         if (data_left != 0) data_left--;
         if (data_left == 0) close_arg(r);
      end else if (stage == HALTED) begin
         r.error_code = lprd_pkg::ERR_HALTED;
      end else begin
         word_acc = {word_acc[23:0], b};
         if (stage != AWAIT_LENGTH && body_left != 0) body_left--;
         field_pos++;
         if (field_pos == 0) begin
            w = word_acc;
            word_acc = '0;
            case (stage)
               AWAIT_LENGTH: begin
                  if (w > 32'(limit_frame)) begin
                     stop_with(r, lprd_pkg::ERR_FRAME_LEN);
                  end else begin
                     body_left = w[25:0];
                     if (body_left < 4) stop_with(r, lprd_pkg::ERR_OVERRUN);
                     else stage = AWAIT_COUNT;
                  end
               end
               AWAIT_COUNT: begin
                  if (w > 32'(limit_args)) begin
                     stop_with(r, lprd_pkg::ERR_ARG_COUNT);
                  end else begin
                     args_pending = w[20:0];
                     arg_number = '0;
                     next_item(r);
                  end
               end
               default: begin
                  if (w > 32'(body_left)) begin
                     stop_with(r, lprd_pkg::ERR_OVERRUN);
                  end else if (w == 0) begin
                     close_arg(r);
                  end else begin
                     data_left = w[25:0];
                     stage = ARG_DATA;
                  end
               end
            endcase
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      lprd_pkg::result_type want;
      if (reset) begin
         stage = AWAIT_LENGTH;
         field_pos = '0;
         word_acc = '0;
         body_left = '0;
         args_pending = '0;
         data_left = '0;
         arg_number = '0;
         limit_frame = lprd_pkg::MAX_FRAME_BYTES_RESET;
         limit_args = lprd_pkg::MAX_ARGUMENTS_RESET;
         expected_results.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               lprd_pkg::CSR_MAX_FRAME_BYTES: limit_frame = csr_mon.data[25:0];
               lprd_pkg::CSR_MAX_ARGUMENTS:   limit_args = csr_mon.data[20:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(deframe_byte(req_mon.in_byte));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none expected",
                                         results_seen));
            end else begin
               want = expected_results.pop_front();
               check_field("arg_byte", 20'(rsp_mon.arg_byte), 20'(want.arg_byte));
               check_field("arg_valid", 20'(rsp_mon.arg_valid), 20'(want.arg_valid));
               check_field("arg_index", rsp_mon.arg_index, want.arg_index);
               check_field("arg_end", 20'(rsp_mon.arg_end), 20'(want.arg_end));
               check_field("frame_done", 20'(rsp_mon.frame_done), 20'(want.frame_done));
               check_field("error_code", 20'(rsp_mon.error_code), 20'(want.error_code));
            end
            results_seen++;
         end
      end
      if (run_done && !end_checked) begin
         if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_results.size()));
         end_checked = 1'b1;
      end
   end

endmodule

FILE: tb/length_prefixed_request_deframer_core_tb.sv
// Top of the deframer testbench: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Depends on lprd_pkg, lprd_ifs, the
// deframer core and length_prefixed_request_deframer_core_checker.
module length_prefixed_request_deframer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int unsigned {
      BAD_FRAME_LEN,
      BAD_SHORT_BODY,
      BAD_ARG_COUNT,
      BAD_HEADER_OVERRUN,
      BAD_DATA_OVERRUN,
      BAD_TRAILING
   } fault_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        run_done = 1'b0;
   int unsigned fail_count;
   int unsigned sent_count = 0;
   int unsigned rsp_count = 0;
   int unsigned burst_left = 0;
   bit          hold_off = 1'b0;

   lprd_req_if req_if ();
   lprd_rsp_if rsp_if ();
   lprd_csr_if csr_if ();

   length_prefixed_request_deframer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   length_prefixed_request_deframer_core_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_mon    (csr_if),
      .run_done   (run_done),
      .fail_count (fail_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) rsp_count <= rsp_count + 1;
   end

   task automatic push_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.in_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_word(input logic [31:0] w);
      push_byte(w[31:24]);
      push_byte(w[23:16]);
      push_byte(w[15:8]);
      push_byte(w[7:0]);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (rsp_count != sent_count) @(posedge clock);
   endtask

   task automatic set_limits(input int unsigned frame_max, input int unsigned args_max);
      drain();
      repeat (3) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= lprd_pkg::CSR_MAX_FRAME_BYTES;
      csr_if.data <= 26'(frame_max);
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.index <= lprd_pkg::CSR_MAX_ARGUMENTS;
      csr_if.data <= {5'($urandom), 21'(args_max)};
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // well-formed request: body length, argument count, then the arguments
   task automatic send_request(input int unsigned n, input int unsigned body);
      int unsigned spare, len, i;
      spare = body - 4 - 4 * n;
      send_word(body);
      send_word(n);
      for (i = 0; i < n; i++) begin
         len = (i == n - 1) ? spare : $urandom_range(0, spare);
         spare -= len;
         send_word(len);
         repeat (len) push_byte(8'($urandom));
      end
   endtask

   task automatic random_frames(input int unsigned budget, input int unsigned frame_cap,
                                input int unsigned args_cap);
      int unsigned stop_at, n, floor_len, top_len, body;
      stop_at = sent_count + budget;
      while (sent_count < stop_at) begin
         n = $urandom_range(0, (args_cap < 6) ? args_cap : 6);
         if ($urandom_range(0, 7) == 0 && args_cap <= 24) n = args_cap;
         floor_len = 4 + 4 * n;
         if (floor_len > frame_cap) begin
            n = (frame_cap - 4) / 4;
            floor_len = 4 + 4 * n;
         end
         top_len = (frame_cap < floor_len + 40) ? frame_cap : floor_len + 40;
         body = (n == 0) ? 4 : $urandom_range(floor_len, top_len);
         if (n != 0 && $urandom_range(0, 7) == 0) body = top_len;
         send_request(n, body);
         if ($urandom_range(0, 40) == 0) drain();
      end
   endtask

   initial begin : rsp_side
      int unsigned mode, left;
      mode = 0;
      left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_if.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(32, 256);
            end
            left--;
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= (left % 5 != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      fault_kind_type fault;
      int unsigned lim, len, extra, args;
      logic [31:0] w;
      req_if.valid <= 1'b0;
      req_if.in_byte <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= '0;
      csr_if.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty request, then one zero-length and one single-byte argument
      send_word(32'd4);
      send_word(32'd0);
      send_word(32'd13);
      send_word(32'd2);
      send_word(32'd0);
      send_word(32'd1);
      push_byte(8'hFF);

      random_frames(400, 160, 1048576);

      set_limits(4, 0);
      random_frames(60, 4, 0);

      set_limits(33554432, 1048576);
      hold_off = 1'b1;
      random_frames(400, 200, 1048576);

      repeat (4) begin
         lim = $urandom_range(8, 120);
         args = $urandom_range(1, 8);
         set_limits(lim, args);
         random_frames(150, lim, args);
      end

      // one malformed request; the block then holds until reset
      fault = fault_kind_type'($urandom_range(0, 5));
      extra = $urandom_range(1, 3);
      len = $urandom_range(0, 12);
      case (fault)
         BAD_FRAME_LEN: begin
            lim = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
            set_limits(lim, 8);
            w = $urandom;
            if (w <= lim) w = lim + 1 + $urandom_range(0, 50);
            send_word(w);
         end
         BAD_SHORT_BODY: begin
            set_limits(200, 8);
            send_word($urandom_range(0, 3));
         end
         BAD_ARG_COUNT: begin
            lim = $urandom_range(0, 10);
            set_limits(1000, lim);
            send_word(32'd200);
            w = $urandom;
            if (w <= lim) w = lim + 1 + $urandom_range(0, 5);
            send_word(w);
         end
         BAD_HEADER_OVERRUN: begin
            set_limits(1000, 8);
            if ($urandom_range(0, 1) == 0) begin
               send_word(4 + extra - 1);
               send_word(32'd1);
            end else begin
               send_word(8 + len + extra - 1);
               send_word(32'd2);
               send_word(len);
               repeat (len) push_byte(8'($urandom));
            end
         end
         BAD_DATA_OVERRUN: begin
            set_limits(1000, 8);
            send_word(8 + len);
            send_word(32'd1);
            send_word(len + extra);
         end
         default: begin
            set_limits(1000, 8);
            if ($urandom_range(0, 1) == 0) begin
               send_word(4 + extra);
               send_word(32'd0);
            end else begin
               send_word(8 + len + extra);
               send_word(32'd1);
               send_word(len);
               repeat (len) push_byte(8'($urandom));
            end
         end
      endcase
      repeat (20) push_byte(8'($urandom));

      drain();
      repeat (10) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0)
         $display("length_prefixed_request_deframer_core verification clean");
      else
         $display("length_prefixed_request_deframer_core verification failed");
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("length_prefixed_request_deframer_core verification failed");
      $finish;
   end

endmodule

FILE: length_prefixed_request_deframer_core.f
+incdir+rtl
rtl/lprd_pkg.sv
rtl/lprd_ifs.sv
rtl/lprd_parse.sv
rtl/lprd_out_buf.sv
rtl/length_prefixed_request_deframer_core.sv
tb/length_prefixed_request_deframer_core_checker.sv
tb/length_prefixed_request_deframer_core_tb.sv
